### hw/rtl/gpenl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpenl_pkg: shared types and constants for the nonlinear phase rotation
// Widths, register codes, the CORDIC angle table and the fixed-point constants.
// ----------------------------------------------------------------------------
package gpenl_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES      = 24;

    localparam int SAMPLE_W = 16;
    localparam int XY_W     = 36;
    localparam int ANG_W    = 32;
    localparam int GUARD    = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [29:0] INV2PI_Q32  = 30'd683565276;
    localparam logic [29:0] INVGAIN_Q30 = 30'd652032874;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [XY_W-1:0]     xy_t;
    typedef logic signed [ANG_W-1:0]    ang_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_SIZE         = 1'b0,
        CFG_SCATTERING_LENGTH = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0]        step_size;
        logic signed [15:0] scattering_length;
    } cfg_t;

    localparam logic [ANG_W-1:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

endpackage

### hw/rtl/gpe_nonlinear_phase_rotation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpe_nonlinear_phase_rotation: real-space nonlinear step of a split-step solver
// Rotates each wavefunction sample by minus dt*(V + 4*pi*a*|psi|^2), modulo a
// full turn, with a chain of CORDIC cells, then saturates to Q3.12.
//
//   Channel  Signals                                    Direction
//   in       in_valid, in_ready, wave_real/imag, potential   sink
//   out      out_valid, out_ready, rotated_real/imag         source
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data       sink
//
// One beat is accepted per cycle while in_ready is high; the pipeline is
// five front stages, one cell per CORDIC iteration and two gain stages.
// Every stage has its own valid bit, so a stalled output only holds the
// stages that are occupied and empty stages keep filling.
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module gpe_nonlinear_phase_rotation #(
    parameter int CORDIC_STAGES = gpenl_pkg::CORDIC_STAGES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  gpenl_pkg::sample_t              wave_real,
    input  gpenl_pkg::sample_t              wave_imag,
    input  logic [15:0]                     potential,
    output logic                            out_valid,
    input  logic                            out_ready,
    output gpenl_pkg::sample_t              rotated_real,
    output gpenl_pkg::sample_t              rotated_imag,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gpenl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                     cfg_data
);
    import gpenl_pkg::*;

    cfg_t cfg_reg;

    logic c_vld [CORDIC_STAGES+1];
    logic c_rdy [CORDIC_STAGES+1];
    xy_t  c_x   [CORDIC_STAGES+1];
    xy_t  c_y   [CORDIC_STAGES+1];
    ang_t c_z   [CORDIC_STAGES+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_size         <= 16'd66;
            cfg_reg.scattering_length <= 16'sd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_STEP_SIZE:         cfg_reg.step_size <= cfg_data;
                CFG_SCATTERING_LENGTH: cfg_reg.scattering_length <= $signed(cfg_data);
                default:               ;
            endcase
        end
    end

    gpenl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .up_vld    (in_valid),
        .up_rdy    (in_ready),
        .wave_real (wave_real),
        .wave_imag (wave_imag),
        .potential (potential),
        .dn_vld    (c_vld[0]),
        .dn_rdy    (c_rdy[0]),
        .x_out     (c_x[0]),
        .y_out     (c_y[0]),
        .z_out     (c_z[0])
    );

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        gpenl_cordic_cell #(
            .STAGE_IDX (i)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .up_vld (c_vld[i]),
            .up_rdy (c_rdy[i]),
            .x_in   (c_x[i]),
            .y_in   (c_y[i]),
            .z_in   (c_z[i]),
            .dn_vld (c_vld[i+1]),
            .dn_rdy (c_rdy[i+1]),
            .x_out  (c_x[i+1]),
            .y_out  (c_y[i+1]),
            .z_out  (c_z[i+1])
        );
    end

    gpenl_gain u_gain (
        .clk    (clk),
        .rst_n  (rst_n),
        .up_vld (c_vld[CORDIC_STAGES]),
        .up_rdy (c_rdy[CORDIC_STAGES]),
        .x_in   (c_x[CORDIC_STAGES]),
        .y_in   (c_y[CORDIC_STAGES]),
        .dn_vld (out_valid),
        .dn_rdy (out_ready),
        .x_out  (rotated_real),
        .y_out  (rotated_imag)
    );

endmodule

### hw/rtl/gpenl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpenl_front: density, phase and quadrant folding
// Five pipeline stages that turn a sample and its potential into the folded
// CORDIC start vector and the residual angle in 32 bit turns.
// ----------------------------------------------------------------------------
module gpenl_front (
    input  logic               clk,
    input  logic               rst_n,
    input  gpenl_pkg::cfg_t    cfg,
    input  logic               up_vld,
    output logic               up_rdy,
    input  gpenl_pkg::sample_t wave_real,
    input  gpenl_pkg::sample_t wave_imag,
    input  logic [15:0]        potential,
    output logic               dn_vld,
    input  logic               dn_rdy,
    output gpenl_pkg::xy_t     x_out,
    output gpenl_pkg::xy_t     y_out,
    output gpenl_pkg::ang_t    z_out
);
    import gpenl_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic r1, r2, r3, r4, r5;

    sample_t            re1_reg, im1_reg, re2_reg, im2_reg, re3_reg, im3_reg;
    sample_t            re4_reg, im4_reg;
    logic [30:0]        sqr1_reg, sqi1_reg;
    logic [31:0]        ps1_reg;
    logic signed [32:0] as1_reg, as2_reg;
    logic [31:0]        dens2_reg;
    logic [55:0]        lin2_reg, lin3_reg;
    logic [52:0]        nl3_reg;
    logic [31:0]        theta4_reg;
    xy_t                x5_reg, y5_reg;
    ang_t               z5_reg;

    logic signed [31:0] sqr_next, sqi_next;
    logic signed [32:0] as_next;
    logic [61:0]        lin_next;
    logic signed [65:0] nl_next;
    logic [55:0]        sum_next;
    logic [31:0]        neg_next;
    xy_t                xs_next, ys_next;

    assign r5 = ~v5_reg | dn_rdy;
    assign r4 = ~v4_reg | r5;
    assign r3 = ~v3_reg | r4;
    assign r2 = ~v2_reg | r3;
    assign r1 = ~v1_reg | r2;
    assign up_rdy = r1;

    assign sqr_next = wave_real * wave_real;
    assign sqi_next = wave_imag * wave_imag;
    assign as_next  = cfg.scattering_length * $signed({1'b0, cfg.step_size});
    assign lin_next = ps1_reg * INV2PI_Q32;
    assign nl_next  = as2_reg * $signed({1'b0, dens2_reg});
    assign sum_next = lin3_reg + {nl3_reg, 3'b000} + 56'd8388608;
    assign neg_next = 32'd0 - theta4_reg;
    assign xs_next  = {{(XY_W-SAMPLE_W-GUARD){re4_reg[SAMPLE_W-1]}}, re4_reg, {GUARD{1'b0}}};
    assign ys_next  = {{(XY_W-SAMPLE_W-GUARD){im4_reg[SAMPLE_W-1]}}, im4_reg, {GUARD{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= up_vld;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
            if (r5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1)
        begin
            re1_reg  <= wave_real;
            im1_reg  <= wave_imag;
            sqr1_reg <= sqr_next[30:0];
            sqi1_reg <= sqi_next[30:0];
            ps1_reg  <= potential * cfg.step_size;
            as1_reg  <= as_next;
        end
        if (r2)
        begin
            re2_reg   <= re1_reg;
            im2_reg   <= im1_reg;
            dens2_reg <= {1'b0, sqr1_reg} + {1'b0, sqi1_reg};
            lin2_reg  <= lin_next[55:0];
            as2_reg   <= as1_reg;
        end
        if (r3)
        begin
            re3_reg  <= re2_reg;
            im3_reg  <= im2_reg;
            lin3_reg <= lin2_reg;
            nl3_reg  <= nl_next[52:0];
        end
        if (r4)
        begin
            re4_reg    <= re3_reg;
            im4_reg    <= im3_reg;
            theta4_reg <= sum_next[55:24];
        end
        if (r5)
        begin
            // Angles outside a quarter turn are folded by a half-turn flip.
            if (neg_next[31] ^ neg_next[30])
            begin
                x5_reg <= -xs_next;
                y5_reg <= -ys_next;
                z5_reg <= {~neg_next[31], neg_next[30:0]};
            end
            else
            begin
                x5_reg <= xs_next;
                y5_reg <= ys_next;
                z5_reg <= neg_next;
            end
        end
    end

    assign dn_vld = v5_reg;
    assign x_out  = x5_reg;
    assign y_out  = y5_reg;
    assign z_out  = z5_reg;

endmodule

### hw/rtl/gpenl_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpenl_cordic_cell: one rotation-mode CORDIC iteration
// Registered micro-rotation by the table angle of its own stage index.
// ----------------------------------------------------------------------------
module gpenl_cordic_cell #(
    parameter int STAGE_IDX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_vld,
    output logic            up_rdy,
    input  gpenl_pkg::xy_t  x_in,
    input  gpenl_pkg::xy_t  y_in,
    input  gpenl_pkg::ang_t z_in,
    output logic            dn_vld,
    input  logic            dn_rdy,
    output gpenl_pkg::xy_t  x_out,
    output gpenl_pkg::xy_t  y_out,
    output gpenl_pkg::ang_t z_out
);
    import gpenl_pkg::*;

    localparam ang_t ATAN_STEP = ang_t'(ATAN_TURNS[STAGE_IDX]);

    logic vld_reg;
    xy_t  x_reg, y_reg, dx, dy;
    ang_t z_reg;

    assign up_rdy = ~vld_reg | dn_rdy;
    assign dx = y_in >>> STAGE_IDX;
    assign dy = x_in >>> STAGE_IDX;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (up_rdy)
        begin
            vld_reg <= up_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_rdy)
        begin
            if (!z_in[ANG_W-1])
            begin
                x_reg <= x_in - dx;
                y_reg <= y_in + dy;
                z_reg <= z_in - ATAN_STEP;
            end
            else
            begin
                x_reg <= x_in + dx;
                y_reg <= y_in - dy;
                z_reg <= z_in + ATAN_STEP;
            end
        end
    end

    assign dn_vld = vld_reg;
    assign x_out  = x_reg;
    assign y_out  = y_reg;
    assign z_out  = z_reg;

endmodule

### hw/rtl/gpenl_gain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpenl_gain: CORDIC gain correction and output saturation
// Two stages: split partial products by 1/K, then round, clamp and hold the
// result beat in the output register.
// ----------------------------------------------------------------------------
module gpenl_gain (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_vld,
    output logic               up_rdy,
    input  gpenl_pkg::xy_t     x_in,
    input  gpenl_pkg::xy_t     y_in,
    output logic               dn_vld,
    input  logic               dn_rdy,
    output gpenl_pkg::sample_t x_out,
    output gpenl_pkg::sample_t y_out
);
    import gpenl_pkg::*;

    localparam int HI_W  = XY_W - GUARD;
    localparam int ACC_W = XY_W + 32;

    logic v1_reg, v2_reg, r1, r2;
    logic signed [HI_W+30:0] xh_reg, yh_reg;
    logic [GUARD+29:0]       xl_reg, yl_reg;
    sample_t                 xo_reg, yo_reg;

    function automatic sample_t finish(input logic signed [HI_W+30:0] ph,
                                       input logic [GUARD+29:0] pl);
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-47:0] r;
        begin
            acc = (ACC_W'(ph) <<< GUARD) + $signed(ACC_W'(pl))
                + $signed(ACC_W'(64'd35184372088832));
            r = acc[ACC_W-1:46];
            if (r > $signed((ACC_W-46)'(32767)))
                finish = 16'sd32767;
            else if (r < -$signed((ACC_W-46)'(32768)))
                finish = -16'sd32768;
            else
                finish = r[15:0];
        end
    endfunction

    assign r2 = ~v2_reg | dn_rdy;
    assign r1 = ~v1_reg | r2;
    assign up_rdy = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= up_vld;
            if (r2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1)
        begin
            xh_reg <= $signed(x_in[XY_W-1:GUARD]) * $signed({1'b0, INVGAIN_Q30});
            yh_reg <= $signed(y_in[XY_W-1:GUARD]) * $signed({1'b0, INVGAIN_Q30});
            xl_reg <= x_in[GUARD-1:0] * INVGAIN_Q30;
            yl_reg <= y_in[GUARD-1:0] * INVGAIN_Q30;
        end
        if (r2)
        begin
            xo_reg <= finish(xh_reg, xl_reg);
            yo_reg <= finish(yh_reg, yl_reg);
        end
    end

    assign dn_vld = v2_reg;
    assign x_out  = xo_reg;
    assign y_out  = yo_reg;

endmodule

### bench/rotation_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_checker: scoreboard for the nonlinear phase rotation
// Watches the sample, result and register channels, keeps its own copy of the
// step size and scattering length, computes the rotated sample for every
// accepted input beat and compares it field by field with the result beats
// in order.
// ----------------------------------------------------------------------------
module rotation_checker #(
    parameter int STAGES = gpenl_pkg::CORDIC_STAGES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  gpenl_pkg::sample_t              wave_real,
    input  gpenl_pkg::sample_t              wave_imag,
    input  logic [15:0]                     potential,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  gpenl_pkg::sample_t              rotated_real,
    input  gpenl_pkg::sample_t              rotated_imag,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [gpenl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                     cfg_data,
    output int                              pending,
    output int                              mismatches
);
    import gpenl_pkg::*;

    typedef struct packed {
        sample_t re;
        sample_t im;
    } rotated_t;

    localparam longint TURN         = 64'sd4294967296;
    localparam longint HALF_TURN    = 64'sd2147483648;
    localparam longint QUARTER_TURN = 64'sd1073741824;
    localparam int     ARC_COUNT    = 24;

    longint arc_turns [0:ARC_COUNT-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    logic [15:0]        dt_reg;
    logic signed [15:0] a_reg;
    rotated_t           expected_rotations [$];

    function automatic sample_t scale_to_sample(input longint v);
        longint t;
        t = (v * 64'sd652032874 + (64'sd1 <<< 45)) >>> 46;
        if (t > 32767)
            t = 32767;
        if (t < -32768)
            t = -32768;
        return sample_t'(t[15:0]);
    endfunction

    function automatic rotated_t predict_rotation(
        input sample_t            re_s,
        input sample_t            im_s,
        input logic [15:0]        pot,
        input logic [15:0]        dt,
        input logic signed [15:0] a_len
    );
        longint          re, im, x, y, z, dx, dy, a_s;
        longint unsigned pot_u, dt_u, a_u, dens, lin, nl, total, theta, negated;
        rotated_t        r;
        re = re_s;
        im = im_s;
        a_s = a_len;
        a_u = a_s;
        pot_u = pot;
        dt_u = dt;
        dens = re * re + im * im;
        lin = pot_u * 64'd683565276 * dt_u;
        nl = a_u * dens * dt_u;
        total = lin + (nl << 3);
        theta = ((total + 64'd8388608) >> 24) & 64'hFFFF_FFFF;
        negated = (64'h1_0000_0000 - theta) & 64'hFFFF_FFFF;
        z = negated;
        if (z >= HALF_TURN)
            z = z - TURN;
        x = re * 65536;
        y = im * 65536;
        if (z >= QUARTER_TURN || z < -QUARTER_TURN)
        begin
            x = -x;
            y = -y;
            z = (z > 0) ? z - HALF_TURN : z + HALF_TURN;
        end
        for (int i = 0; i < STAGES && i < ARC_COUNT; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - arc_turns[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + arc_turns[i];
            end
        end
        r.re = scale_to_sample(x);
        r.im = scale_to_sample(y);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rotated_t due;
        int       fails;
        if (!rst_n)
        begin
            dt_reg <= 16'd66;
            a_reg <= '0;
            expected_rotations.delete();
            pending <= 0;
            mismatches <= 0;
        end
        else
        begin
            fails = 0;
            if (out_valid && out_ready)
            begin
                if (expected_rotations.size() == 0)
                begin
                    $error("result beat with no sample outstanding: real %0d imag %0d",
                           rotated_real, rotated_imag);
                    fails++;
                end
                else
                begin
                    due = expected_rotations.pop_front();
                    if (rotated_real !== due.re)
                    begin
                        $error("rotated_real: expected %0d, actual %0d", due.re, rotated_real);
                        fails++;
                    end
                    if (rotated_imag !== due.im)
                    begin
                        $error("rotated_imag: expected %0d, actual %0d", due.im, rotated_imag);
                        fails++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_rotations.push_back(
                    predict_rotation(wave_real, wave_imag, potential, dt_reg, a_reg));
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_STEP_SIZE)
                    dt_reg <= cfg_data;
                else if (cfg_index == CFG_SCATTERING_LENGTH)
                    a_reg <= cfg_data;
            end
            mismatches <= mismatches + fails;
            pending <= expected_rotations.size();
        end
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for gpe_nonlinear_phase_rotation
// Drives directed corner samples and several register settings, then random
// samples in phases with new step sizes and scattering lengths, with random
// input gaps and output stalls except in the last phase. A separate checker
// predicts every rotated sample and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;
    import gpenl_pkg::*;

    localparam int STAGES      = CORDIC_STAGES_DEF;
    localparam int LATENCY     = STAGES + 7;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 5;
    localparam int PHASE_BEATS = 250;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    sample_t  wave_real = '0;
    sample_t  wave_imag = '0;
    logic [15:0] potential = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    sample_t  rotated_real;
    sample_t  rotated_imag;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    cfg_idx_t cfg_index = CFG_STEP_SIZE;
    logic [15:0] cfg_data = '0;

    int pending;
    int mismatches;
    int items_sent = 0;
    int settings_used = 1;
    int quiet_cycles = 0;
    int stall_left = 0;
    bit gaps_on = 1'b1;
    bit stalls_on = 1'b1;

    gpe_nonlinear_phase_rotation #(
        .CORDIC_STAGES(STAGES)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .wave_real    (wave_real),
        .wave_imag    (wave_imag),
        .potential    (potential),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .rotated_real (rotated_real),
        .rotated_imag (rotated_imag),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    rotation_checker #(
        .STAGES(STAGES)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .wave_real    (wave_real),
        .wave_imag    (wave_imag),
        .potential    (potential),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .rotated_real (rotated_real),
        .rotated_imag (rotated_imag),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pending      (pending),
        .mismatches   (mismatches)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (stalls_on && $urandom_range(0, 15) == 0)
        begin
            stall_left <= $urandom_range(0, 18);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int pick_corner();
        case ($urandom_range(0, 4))
            0:       return -32768;
            1:       return -1;
            2:       return 0;
            3:       return 1;
            default: return 32767;
        endcase
    endfunction

    task automatic send_sample(input int re_v, input int im_v, input int pot_v);
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        wave_real <= sample_t'(re_v);
        wave_imag <= sample_t'(im_v);
        potential <= 16'(pot_v);
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    task automatic program_registers(input logic [15:0] dt, input logic [15:0] a_len);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_STEP_SIZE;
        cfg_data <= dt;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= CFG_SCATTERING_LENGTH;
        cfg_data <= a_len;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        int re_v;
        int im_v;
        int pot_v;
        logic [15:0] dt_v;
        logic [15:0] a_v;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_sample(0, 0, 0);
        send_sample(32767, 32767, 65535);
        send_sample(-32768, -32768, 0);
        send_sample(32767, -32768, 12345);
        send_sample(-32768, 32767, 65535);
        send_sample(4096, 0, 256);
        send_sample(0, 4096, 0);
        send_sample(-1, -1, 1);

        program_registers(16'hFFFF, 16'h0000);
        send_sample(32767, 32767, 201);
        send_sample(-32768, -32768, 201);
        send_sample(32767, 0, 402);
        send_sample(0, -32768, 603);
        send_sample(4096, 4096, 65535);

        program_registers(16'hFFFF, 16'h7FFF);
        send_sample(32767, 32767, 65535);
        send_sample(-32768, 32767, 0);
        send_sample(1000, -2000, 300);

        program_registers(16'h0000, 16'h8000);
        send_sample(32767, -32768, 65535);
        send_sample(123, 456, 789);

        program_registers(16'h0001, 16'h8000);
        send_sample(32767, 32767, 65535);
        send_sample(-32768, -32768, 0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case ($urandom_range(0, 4))
                0:       dt_v = 16'h0000;
                1:       dt_v = 16'hFFFF;
                2:       dt_v = 16'd66;
                3:       dt_v = 16'($urandom_range(1, 400));
                default: dt_v = 16'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 3))
                0:       a_v = 16'h8000;
                1:       a_v = 16'h7FFF;
                2:       a_v = 16'h0000;
                default: a_v = 16'($urandom_range(0, 65535));
            endcase
            if (phase == PHASES - 1)
            begin
                gaps_on = 1'b0;
                stalls_on <= 1'b0;
            end
            program_registers(dt_v, a_v);
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        re_v = $urandom_range(0, 65535);
                        im_v = $urandom_range(0, 65535);
                        pot_v = $urandom_range(0, 65535);
                    end
                    1:
                    begin
                        re_v = int'($urandom_range(0, 8192)) - 4096;
                        im_v = int'($urandom_range(0, 8192)) - 4096;
                        pot_v = $urandom_range(0, 2047);
                    end
                    2:
                    begin
                        re_v = pick_corner();
                        im_v = pick_corner();
                        pot_v = ($urandom_range(0, 1) == 0) ? 0 : 65535;
                    end
                    default:
                    begin
                        re_v = $urandom_range(0, 65535);
                        im_v = int'($urandom_range(0, 8192)) - 4096;
                        pot_v = ($urandom_range(0, 1) == 0) ? 65535 : $urandom_range(0, 65535);
                    end
                endcase
                send_sample(re_v, im_v, pot_v);
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);

        $display("Rotated %0d samples under %0d register settings, from corner values",
                 items_sent, settings_used);
        $display("through saturating and multi-turn phases, with random gaps and stalls.");
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/gpenl_pkg.sv
hw/rtl/gpenl_front.sv
hw/rtl/gpenl_cordic_cell.sv
hw/rtl/gpenl_gain.sv
hw/rtl/gpe_nonlinear_phase_rotation.sv
bench/rotation_checker.sv
bench/testbench.sv
